>>> hw/rtl/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared widths, register indexes, reset values and the coordinate clamp
// for the bright spot centroid unit.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int LUMA_W   = 8;
    localparam int WEIGHT_W = 28;
    localparam int MOMENT_W = 38;
    localparam int COORD_W  = 10;
    localparam int CFG_SZ_W = 11;
    // Wide enough for any frame size up to the largest parameter value.
    localparam int SIZE_W   = 13;
    localparam int OUT_W    = 56;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [1:0] CFG_MIN_WEIGHT = 2'd1;
    localparam logic [1:0] CFG_WIDTH      = 2'd2;
    localparam logic [1:0] CFG_HEIGHT     = 2'd3;

    localparam logic [LUMA_W-1:0]   RST_THRESHOLD  = 8'd220;
    localparam logic [WEIGHT_W-1:0] RST_MIN_WEIGHT = 28'd50;
    localparam logic [CFG_SZ_W-1:0] RST_WIDTH      = 11'd640;
    localparam logic [CFG_SZ_W-1:0] RST_HEIGHT     = 11'd480;

    // A centroid of zero moves in to one; one at or past the last line moves
    // in to the line before it.
    function automatic logic [COORD_W-1:0] place_coord(
        input logic [MOMENT_W-1:0] q,
        input logic [SIZE_W-1:0]   size_m1
    );
        logic [MOMENT_W-1:0] c;
        c = q;
        if (c == '0) begin
            c = MOMENT_W'(1);
        end
        if (c >= MOMENT_W'(size_m1)) begin
            c = MOMENT_W'(size_m1 - SIZE_W'(1));
        end
        return c[COORD_W-1:0];
    endfunction

endpackage

>>> hw/rtl/bsc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_div
// Restoring divider, one quotient bit per cycle, shared by both axes.
// ----------------------------------------------------------------------------
module bsc_div
    import bsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MOMENT_W-1:0] i_dividend,
    input  logic [WEIGHT_W-1:0] i_divisor,
    output logic                o_done,
    output logic [MOMENT_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(MOMENT_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [MOMENT_W-1:0] r_quo;
    logic [WEIGHT_W-1:0] r_rem;
    logic [WEIGHT_W-1:0] r_dvs;

    logic [WEIGHT_W:0]   trial;
    logic [WEIGHT_W:0]   diff;
    logic                fits;

    assign trial = {r_rem, r_quo[MOMENT_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MOMENT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out of the top while quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[MOMENT_W-2:0], fits};
            r_rem <= fits ? diff[WEIGHT_W-1:0] : trial[WEIGHT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> hw/rtl/bright_spot_centroid_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bright_spot_centroid_unit
// Thresholded, luma-weighted centroid of one frame of raster-order pixels.
// ----------------------------------------------------------------------------
// Pixels enter on the slave stream: luma in tdata, tlast on the last pixel of
// the frame. Column and row are counted internally. A pixel brighter than the
// threshold adds its luma to the weight and luma times column and row to the
// two moment sums, one product per cycle through a single multiplier; the next
// pixel is taken (s_axis_tready high) only after both products are done.
// On tlast the frame result appears on the master stream. If a spot is
// found both centroids go through one restoring divider at one bit a cycle,
// column first, then row; without a spot no division is done.
// The result sits in an output register; further pixels are taken while it
// waits. A later frame end holds off until the receiver has taken it.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data only
// while the block is idle; the user must keep to this, the block does not
// enforce it. Reset restores the register defaults (threshold 220, minimum
// weight 50, 640 x 480) and clears all counters and sums.
// ----------------------------------------------------------------------------
module bright_spot_centroid_unit
    import bsc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [WEIGHT_W-1:0] i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [LUMA_W-1:0]   s_axis_tdata,  // luma[7:0]
    input  logic                s_axis_tlast,  // frame_end
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // spot_found[0], center_x[10:1], center_y[20:11], weight_total[48:21]
    output logic [OUT_W-1:0]    m_axis_tdata
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int OP_W = (CW > RW) ? CW : RW;
    localparam int PR_W = LUMA_W + OP_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MX   = 3'd1;
    localparam logic [2:0] S_MY   = 3'd2;
    localparam logic [2:0] S_DIVX = 3'd3;
    localparam logic [2:0] S_DIVY = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [LUMA_W-1:0]   r_threshold;
    logic [WEIGHT_W-1:0] r_min_weight;
    logic [CFG_SZ_W-1:0] r_frame_width;
    logic [CFG_SZ_W-1:0] r_frame_height;

    logic [LUMA_W-1:0]   r_luma;
    logic                r_last;
    logic [CW-1:0]       r_col;
    logic [RW-1:0]       r_row;
    logic [WEIGHT_W-1:0] r_weight;
    logic [MOMENT_W-1:0] r_mx;
    logic [MOMENT_W-1:0] r_my;
    logic                r_found;
    logic [COORD_W-1:0]  r_cx;
    logic [COORD_W-1:0]  r_cy;
    logic                r_m_valid;
    logic [OUT_W-1:0]    r_m_data;

    logic [SIZE_W-1:0]   w_clamp, h_clamp, w_m1_full, h_m1_full;
    logic [CW-1:0]       w_m1;
    logic [RW-1:0]       h_m1;
    logic                bright;
    logic [OP_W-1:0]     mul_op;
    logic [PR_W-1:0]     product;
    logic [MOMENT_W:0]   mom_base, mom_sum;
    logic [MOMENT_W-1:0] mom_sat;
    logic [WEIGHT_W:0]   wt_sum;
    logic [WEIGHT_W-1:0] wt_sat;
    logic                div_start, div_done;
    logic [MOMENT_W-1:0] div_quo;
    logic                s_accept, out_free;

    always_comb begin
        w_clamp = SIZE_W'(r_frame_width);
        if (w_clamp < SIZE_W'(3)) begin
            w_clamp = SIZE_W'(3);
        end else if (w_clamp > SIZE_W'(MAX_WIDTH)) begin
            w_clamp = SIZE_W'(MAX_WIDTH);
        end
        h_clamp = SIZE_W'(r_frame_height);
        if (h_clamp < SIZE_W'(3)) begin
            h_clamp = SIZE_W'(3);
        end else if (h_clamp > SIZE_W'(MAX_HEIGHT)) begin
            h_clamp = SIZE_W'(MAX_HEIGHT);
        end
    end

    assign w_m1_full = w_clamp - SIZE_W'(1);
    assign h_m1_full = h_clamp - SIZE_W'(1);
    assign w_m1      = w_m1_full[CW-1:0];
    assign h_m1      = h_m1_full[RW-1:0];

    assign bright = r_luma > r_threshold;

    // The one multiplier serves the column moment, then the row moment.
    assign mul_op   = (r_state == S_MX) ? OP_W'(r_col) : OP_W'(r_row);
    assign product  = PR_W'(r_luma) * PR_W'(mul_op);
    assign mom_base = (r_state == S_MX) ? {1'b0, r_mx} : {1'b0, r_my};
    assign mom_sum  = mom_base + (MOMENT_W + 1)'(product);
    assign mom_sat  = mom_sum[MOMENT_W] ? '1 : mom_sum[MOMENT_W-1:0];
    assign wt_sum   = {1'b0, r_weight} + (WEIGHT_W + 1)'(r_luma);
    assign wt_sat   = wt_sum[WEIGHT_W] ? '1 : wt_sum[WEIGHT_W-1:0];

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    assign div_start = ((r_state == S_MY) && r_last && (r_weight > r_min_weight))
                    || ((r_state == S_DIVX) && div_done);

    bsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ((r_state == S_DIVX) ? r_my : r_mx),
        .i_divisor  (r_weight),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_MX;
                end
            end
            S_MX: begin
                n_state = S_MY;
            end
            S_MY: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_weight > r_min_weight) begin
                    n_state = S_DIVX;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIVX: begin
                if (div_done) begin
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_threshold    <= RST_THRESHOLD;
            r_min_weight   <= RST_MIN_WEIGHT;
            r_frame_width  <= RST_WIDTH;
            r_frame_height <= RST_HEIGHT;
            r_col          <= '0;
            r_row          <= '0;
            r_weight       <= '0;
            r_mx           <= '0;
            r_my           <= '0;
            r_found        <= 1'b0;
            r_m_valid      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_THRESHOLD:  r_threshold    <= i_cfg_data[LUMA_W-1:0];
                    CFG_MIN_WEIGHT: r_min_weight   <= i_cfg_data;
                    CFG_WIDTH:      r_frame_width  <= i_cfg_data[CFG_SZ_W-1:0];
                    CFG_HEIGHT:     r_frame_height <= i_cfg_data[CFG_SZ_W-1:0];
                    default:        r_threshold    <= r_threshold;
                endcase
            end

            case (r_state)
                S_MX: begin
                    if (bright) begin
                        r_weight <= wt_sat;
                        r_mx     <= mom_sat;
                    end
                end
                S_MY: begin
                    if (bright) begin
                        r_my <= mom_sat;
                    end
                    r_found <= r_weight > r_min_weight;
                    // The counters stand still on the frame's last pixel.
                    if (!r_last) begin
                        if (r_col >= w_m1) begin
                            r_col <= '0;
                            r_row <= (r_row >= h_m1) ? '0 : r_row + RW'(1);
                        end else begin
                            r_col <= r_col + CW'(1);
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_col    <= '0;
                        r_row    <= '0;
                        r_weight <= '0;
                        r_mx     <= '0;
                        r_my     <= '0;
                    end
                end
                default: begin
                    r_col <= r_col;
                end
            endcase

            if ((r_state == S_FIN) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_luma <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
        if ((r_state == S_DIVX) && div_done) begin
            r_cx <= place_coord(div_quo, SIZE_W'(w_m1));
        end
        if ((r_state == S_DIVY) && div_done) begin
            r_cy <= place_coord(div_quo, SIZE_W'(h_m1));
        end
        if ((r_state == S_FIN) && out_free) begin
            r_m_data <= OUT_W'({r_weight,
                                r_found ? r_cy : COORD_W'(0),
                                r_found ? r_cx : COORD_W'(0),
                                r_found});
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

>>> hw/rtl/bsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks for the bright spot centroid unit, bound to the top.
// ----------------------------------------------------------------------------
module bsc_checker
    import bsc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // A held result must not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Once a pixel is taken, s_axis_tready drops.
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("pixel taken on consecutive cycles");

    // Without a spot the centre fields read zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[20:1] == 20'd0)
        else $error("centre reported without a spot");

    // A spot needs a weight above the minimum, hence never zero.
    a_hit_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[48:21] != 28'd0)
        else $error("spot reported with zero weight");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind bright_spot_centroid_unit bsc_checker u_bsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
